>>> hw/rtl/lprt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprt_pkg
// Shared types and constants of the LRU page replacement block.
// ----------------------------------------------------------------------------
package lprt_pkg;

  localparam int LFSR_W      = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_INIT = 16'h0001;
  localparam int LFSR_CNT_W  = $clog2(LFSR_W);

  localparam int IN_PAGE_W   = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FRAME_W = 2;
  localparam int OUT_PAGE_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SEL  = 5'b01000,
    ST_UPD  = 5'b10000
  } state_t;

  typedef struct packed {
    logic en;
    logic alloc;
  } upd_cmd_t;

endpackage

>>> hw/rtl/lprt_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprt_mod_unit
// Bit-serial remainder unit: LFSR value modulo a small count, one bit a cycle.
// ----------------------------------------------------------------------------
module lprt_mod_unit #(
  parameter int DIV_W = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lprt_pkg::LFSR_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [DIV_W-1:0]          rem
);
  import lprt_pkg::*;

  localparam logic [LFSR_CNT_W-1:0] LAST_STEP = LFSR_CNT_W'(LFSR_W - 1);

  logic                  active_r, active_nxt;
  logic                  done_r, done_nxt;
  logic [LFSR_CNT_W-1:0] step_r, step_nxt;
  logic [LFSR_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]      div_r, div_nxt;
  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [DIV_W:0]        trial;

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    quo_nxt    = quo_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    trial      = {rem_r, quo_r[LFSR_W-1]};
    if (start) begin
      active_nxt = 1'b1;
      step_nxt   = '0;
      quo_nxt    = dividend;
      div_nxt    = divisor;
      rem_nxt    = '0;
    end else if (active_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      quo_nxt  = {quo_r[LFSR_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      step_r   <= step_nxt;
    end
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> hw/rtl/lprt_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprt_frame_store
// Frame valid bits, page numbers and recency ranks; one read port, LRU update.
// ----------------------------------------------------------------------------
module lprt_frame_store #(
  parameter int FRAME_COUNT = 4,
  parameter int PAGE_BITS   = 16,
  parameter int IDX_W       = 2,
  parameter int RANK_W      = 2,
  parameter int CNT_W       = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic                 rd_valid,
  output logic [PAGE_BITS-1:0] rd_page,
  output logic [RANK_W-1:0]    rd_rank,
  input  lprt_pkg::upd_cmd_t   upd,
  input  logic [IDX_W-1:0]     upd_idx,
  input  logic [CNT_W-1:0]     upd_limit,
  input  logic [PAGE_BITS-1:0] upd_page
);
  import lprt_pkg::*;

  logic                 valid_r [FRAME_COUNT];
  logic                 valid_nxt [FRAME_COUNT];
  logic [RANK_W-1:0]    rank_r [FRAME_COUNT];
  logic [RANK_W-1:0]    rank_nxt [FRAME_COUNT];
  logic [PAGE_BITS-1:0] page_r [FRAME_COUNT];

  assign rd_valid = valid_r[rd_idx];
  assign rd_page  = page_r[rd_idx];
  assign rd_rank  = rank_r[rd_idx];

  // touch: chosen frame becomes youngest, younger valid frames age by one
  always_comb begin
    for (int i = 0; i < FRAME_COUNT; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
      if (upd.en) begin
        if (IDX_W'(i) == upd_idx) begin
          rank_nxt[i] = '0;
          if (upd.alloc) begin
            valid_nxt[i] = 1'b1;
          end
        end else if (valid_r[i] && (CNT_W'(rank_r[i]) < upd_limit)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end else begin
        valid_r[i] <= valid_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
    end
    if (upd.en && upd.alloc) begin
      page_r[upd_idx] <= upd_page;
    end
  end

endmodule

>>> hw/rtl/lru_page_replace_random_tie.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replace_random_tie
// Fully associative LRU page replacement with LFSR choice among empty frames.
// ----------------------------------------------------------------------------
// Each page access word is handled by a sequencer around one shared frame
// compare: frames are scanned one per cycle through a single read port. A hit
// or a miss with all frames full needs only this scan before the update, and a
// hit stops the scan early. A miss while frames are still empty also runs a
// bit-serial modulo of the LFSR by the empty count and a second pass over the
// frames to pick the k-th empty frame; this happens only on the first
// FRAME_COUNT misses after reset. in_tready is low while a word is at work.
// The result sits in an output register so the next word can be accepted
// while it waits. There is no clearing pass after reset.
module lru_page_replace_random_tie #(
  parameter int FRAME_COUNT = 4,
  parameter int PAGE_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: page_number[15:0]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lprt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: frame_index[1:0], evicted_valid[2], evicted_page[18:3], zero
  // out_tuser: hit[0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lprt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,
  // cfg_data: random_seed[15:0]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lprt_pkg::LFSR_W-1:0]        cfg_data
);
  import lprt_pkg::*;

  localparam int IDX_W  = $clog2(FRAME_COUNT);
  localparam int RANK_W = $clog2(FRAME_COUNT);
  localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_COUNT - 1);
  localparam logic [CNT_W-1:0] FULL_LIMIT = CNT_W'(FRAME_COUNT);

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [CNT_W-1:0]     empty_cnt_r, empty_cnt_nxt;
  logic [RANK_W-1:0]    oldest_r, oldest_nxt;
  logic [IDX_W-1:0]     victim_r, victim_nxt;
  logic [PAGE_BITS-1:0] ev_page_r, ev_page_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic                 hit_r, hit_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [LFSR_W-1:0]    lfsr_r, lfsr_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r;
  logic [OUT_FRAME_W-1:0] out_frame_r;
  logic                   out_ev_valid_r;
  logic [OUT_PAGE_W-1:0]  out_ev_page_r;

  logic                 rd_valid;
  logic [PAGE_BITS-1:0] rd_page;
  logic [RANK_W-1:0]    rd_rank;
  upd_cmd_t             upd;
  logic                 upd_fire;
  logic                 in_fire;
  logic                 div_start;
  logic                 div_done;
  logic [CNT_W-1:0]     div_rem;
  logic [CNT_W-1:0]     cnt_scan;
  logic [PAGE_BITS+IN_PAGE_W-1:0] in_page_ext;
  logic [PAGE_BITS+OUT_PAGE_W-1:0] ev_page_ext;
  logic [IDX_W+OUT_FRAME_W-1:0]   victim_ext;

  assign in_tready   = (state_r == ST_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  assign cfg_ready   = 1'b1;
  assign upd_fire    = (state_r == ST_UPD) && (!out_valid_r || out_tready);
  assign in_page_ext = {{PAGE_BITS{1'b0}}, in_tdata[IN_PAGE_W-1:0]};
  assign ev_page_ext = {{OUT_PAGE_W{1'b0}}, ev_page_r};
  assign victim_ext  = {{OUT_FRAME_W{1'b0}}, victim_r};

  assign upd.en    = upd_fire;
  assign upd.alloc = !hit_r;

  lprt_frame_store #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BITS   (PAGE_BITS),
    .IDX_W       (IDX_W),
    .RANK_W      (RANK_W),
    .CNT_W       (CNT_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx_r),
    .rd_valid  (rd_valid),
    .rd_page   (rd_page),
    .rd_rank   (rd_rank),
    .upd       (upd),
    .upd_idx   (victim_r),
    .upd_limit (limit_r),
    .upd_page  (page_r)
  );

  lprt_mod_unit #(
    .DIV_W (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lfsr_r),
    .divisor  (cnt_scan),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    page_nxt      = page_r;
    empty_cnt_nxt = empty_cnt_r;
    oldest_nxt    = oldest_r;
    victim_nxt    = victim_r;
    ev_page_nxt   = ev_page_r;
    ev_valid_nxt  = ev_valid_r;
    hit_nxt       = hit_r;
    limit_nxt     = limit_r;
    k_nxt         = k_r;
    lfsr_nxt      = lfsr_r;
    div_start     = 1'b0;
    cnt_scan      = empty_cnt_r + CNT_W'(!rd_valid);
    if (idx_r == '0) begin
      cnt_scan = CNT_W'(!rd_valid);
    end

    if (cfg_valid && cfg_ready) begin
      lfsr_nxt = (cfg_data == '0) ? LFSR_INIT : cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          page_nxt     = in_page_ext[PAGE_BITS-1:0];
          idx_nxt      = '0;
          hit_nxt      = 1'b0;
          ev_valid_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        empty_cnt_nxt = cnt_scan;
        if ((idx_r == '0) || (rd_rank > oldest_r)) begin
          oldest_nxt  = rd_rank;
          victim_nxt  = idx_r;
          ev_page_nxt = rd_page;
        end
        if (rd_valid && (rd_page == page_r)) begin
          hit_nxt    = 1'b1;
          victim_nxt = idx_r;
          limit_nxt  = CNT_W'(rd_rank);
          state_nxt  = ST_UPD;
        end else if (idx_r == LAST_IDX) begin
          limit_nxt = FULL_LIMIT;
          idx_nxt   = '0;
          if (cnt_scan != '0) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            ev_valid_nxt = 1'b1;
            state_nxt    = ST_UPD;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DIV: begin
        victim_nxt = '0;
        if (div_done) begin
          k_nxt     = div_rem;
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        if (!rd_valid) begin
          if (k_r == '0) begin
            victim_nxt = idx_r;
            state_nxt  = ST_UPD;
          end else begin
            k_nxt = k_r - 1'b1;
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_UPD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_UPD: begin
        if (upd_fire) begin
          if (!hit_r) begin
            lfsr_nxt = lfsr_r >> 1;
            if (lfsr_r[0]) begin
              lfsr_nxt = (lfsr_r >> 1) ^ LFSR_TAPS;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (upd_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lfsr_r      <= LFSR_INIT;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    page_r      <= page_nxt;
    empty_cnt_r <= empty_cnt_nxt;
    oldest_r    <= oldest_nxt;
    victim_r    <= victim_nxt;
    ev_page_r   <= ev_page_nxt;
    ev_valid_r  <= ev_valid_nxt;
    hit_r       <= hit_nxt;
    limit_r     <= limit_nxt;
    k_r         <= k_nxt;
    if (upd_fire) begin
      out_hit_r      <= hit_r;
      out_frame_r    <= victim_ext[OUT_FRAME_W-1:0];
      out_ev_valid_r <= ev_valid_r;
      out_ev_page_r  <= ev_valid_r ? ev_page_ext[OUT_PAGE_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_PAGE_W - OUT_FRAME_W - 1){1'b0}},
                       out_ev_page_r, out_ev_valid_r, out_frame_r};

`ifndef SYNTH
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SCAN))
    else $error("accepted word did not start a scan");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (!out_ev_valid_r && (out_ev_page_r == '0)))
    else $error("hit result reports an eviction");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (empty_cnt_r != '0))
    else $error("modulo started with zero empty frames");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while held");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (lfsr_r != '0))
    else $error("tie-break LFSR reached zero");
`endif

endmodule
